>>> sv/lz_backref_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// lz_backref_stream_decoder_assert.svh
// Assertion macros used by the LZ back-reference decoder checker.
// ----------------------------------------------------------------------------
`ifndef LZ_BACKREF_STREAM_DECODER_ASSERT_SVH
`define LZ_BACKREF_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LZBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LZBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lzbr_pkg.sv
// ----------------------------------------------------------------------------
// lzbr_pkg
// Shared constants, status codes and window port types for the LZ decoder.
// ----------------------------------------------------------------------------
package lzbr_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int BEAT_BYTES   = 8;
  localparam int HEADER_BYTES = 16;

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int HW      = $clog2(HEADER_BYTES + 2);
  localparam int DIST_W  = 13;   // distance 1..4096
  localparam int LEN_W   = 9;    // run length 3..273
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 4;

  localparam logic [LEN_W-1:0] LEN_SHORT_BIAS = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_LONG_BIAS  = LEN_W'(18);
  localparam logic [3:0]       FLAGS_PER_CODE = 4'd8;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_BEFORE_START = 2'd1;
  localparam logic [1:0] STATUS_CLIPPED      = 2'd2;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } win_wr_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic          zero;   // source lies before the stream start
  } win_rd_t;

endpackage

>>> sv/lzbr_window.sv
// ----------------------------------------------------------------------------
// lzbr_window
// History window: one write and one registered read per cycle, with
// write-to-read forwarding and a zero mask for never-written entries.
// ----------------------------------------------------------------------------
module lzbr_window (
  input  logic              clk,
  input  lzbr_pkg::win_wr_t wr,
  input  lzbr_pkg::win_rd_t rd,
  output logic [7:0]        rd_data
);
  import lzbr_pkg::*;

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_r;
  logic       zero_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    // read port holds its data while the engine is stalled
    if (rd.en) begin
      q_r        <= mem[rd.addr];
      fwd_r      <= wr.en && (wr.addr == rd.addr);
      fwd_data_r <= wr.data;
      zero_r     <= rd.zero;
    end
  end

  assign rd_data = zero_r ? 8'd0 : (fwd_r ? fwd_data_r : q_r);

endmodule

>>> sv/lz_backref_stream_decoder.sv
// ----------------------------------------------------------------------------
// lz_backref_stream_decoder
// Streaming LZ77 back-reference decoder (Yaz0 format), one compressed byte
// per request in, beats of up to eight decompressed bytes out.
//
// Each header, code and reference byte is consumed as it is accepted. A
// literal leaves as a one-byte beat. A back-reference (its length clipped to
// output_size) is copied one byte a cycle, while the output is not stalled,
// through the single read port of the 4096-byte history window, whose read is
// registered, and bytes are packed into beats of eight; no new input request
// is taken during a run. The window needs no clearing pass after reset: bytes
// read from before the stream start are masked to zero, so the block is ready
// as soon as it leaves reset. Output backpressure stalls the copy engine in
// place. output_size is written through the cfg port only while the block is
// between requests; writing it never restarts the stream.
// ----------------------------------------------------------------------------
module lz_backref_stream_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input byte channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  // result beat channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lzbr_pkg::DATA_W-1:0] out_data,
  output logic [lzbr_pkg::CNT_W-1:0]  out_count,
  output logic                        out_run_last,
  output logic                        out_stream_done,
  output logic [1:0]                  out_status,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [31:0]                 cfg_output_size
);
  import lzbr_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;
  typedef enum logic [1:0] {PH_CODE, PH_ITEM, PH_SECOND, PH_THIRD} phase_t;

  // control state
  state_t            state_r,      state_nxt;
  phase_t            phase_r,      phase_nxt;
  logic [HW-1:0]     hdr_cnt_r,    hdr_cnt_nxt;
  logic [7:0]        flag_bits_r,  flag_bits_nxt;
  logic [3:0]        flags_left_r, flags_left_nxt;
  logic [31:0]       bp_r,         bp_nxt;       // bytes produced so far
  logic [31:0]       out_size_r,   out_size_nxt;
  logic [LEN_W-1:0]  rd_left_r,    rd_left_nxt;  // reads still to issue
  logic [LEN_W-1:0]  run_left_r,   run_left_nxt; // bytes still to write
  logic              st_v_r,       st_v_nxt;     // read in flight
  logic [BEAT_BYTES > 1 ? 2 : 2:0] beat_cnt_r, beat_cnt_nxt;
  logic              out_valid_r,  out_valid_nxt;

  // payload state
  logic [7:0]        ref1_r,       ref1_nxt;
  logic [7:0]        ref2_r,       ref2_nxt;
  logic [AW-1:0]     rp_r,         rp_nxt;
  logic [DIST_W-1:0] zeros_r,      zeros_nxt;    // masked reads left
  logic [1:0]        run_status_r, run_status_nxt;
  logic [DATA_W-1:0] beat_data_r,  beat_data_nxt;
  logic [DATA_W-1:0] out_data_r,   out_data_nxt;
  logic [CNT_W-1:0]  out_count_r,  out_count_nxt;
  logic              out_last_r,   out_last_nxt;
  logic              out_done_r,   out_done_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  win_wr_t    win_wr;
  win_rd_t    win_rd;
  logic [7:0] win_q;

  lzbr_window u_window (
    .clk     (clk),
    .wr      (win_wr),
    .rd      (win_rd),
    .rd_data (win_q)
  );

  logic out_free;
  logic in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    logic [3:0]        fin_left;
    logic [7:0]        dist_lo;
    logic [DIST_W-1:0] ref_dist;
    logic [LEN_W-1:0]  len_sel;
    logic [LEN_W-1:0]  len_c;
    logic [31:0]       remain;
    logic [31:0]       bp_inc;
    logic              clip;
    logic              pre_start;
    logic              push;
    logic [DATA_W-1:0] beat_ins;

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    bp_nxt         = bp_r;
    out_size_nxt   = out_size_r;
    rd_left_nxt    = rd_left_r;
    run_left_nxt   = run_left_r;
    st_v_nxt       = st_v_r;
    beat_cnt_nxt   = beat_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ref1_nxt       = ref1_r;
    ref2_nxt       = ref2_r;
    rp_nxt         = rp_r;
    zeros_nxt      = zeros_r;
    run_status_nxt = run_status_r;
    beat_data_nxt  = beat_data_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    win_wr         = '0;
    win_rd         = '0;

    // end-of-item bookkeeping: next flag bit, or a new code byte
    fin_left = (flags_left_r != 4'd0) ? flags_left_r - 4'd1 : 4'd0;
    bp_inc   = bp_r + 32'd1;

    // run setup; low distance byte is live on the second byte, stored after
    dist_lo   = (phase_r == PH_SECOND) ? in_byte : ref2_r;
    ref_dist  = {1'b0, ref1_r[3:0], dist_lo} + DIST_W'(1);
    len_sel   = (phase_r == PH_SECOND) ? LEN_W'(ref1_r[7:4]) + LEN_SHORT_BIAS
                                       : LEN_W'(in_byte) + LEN_LONG_BIAS;
    remain    = out_size_r - bp_r;
    clip      = 32'(len_sel) > remain;
    len_c     = clip ? remain[LEN_W-1:0] : len_sel;
    pre_start = (bp_r[31:DIST_W] == '0) && (bp_r[DIST_W-1:0] < ref_dist);

    push     = st_v_r && ((beat_cnt_r == 3'(BEAT_BYTES - 1)) || (run_left_r == LEN_W'(1)));
    beat_ins = beat_data_r;
    beat_ins[{beat_cnt_r, 3'b000} +: 8] = win_q;

    if (cfg_valid && cfg_ready) begin
      out_size_nxt = cfg_output_size;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (hdr_cnt_r < HW'(HEADER_BYTES)) begin
            hdr_cnt_nxt = hdr_cnt_r + HW'(1);
          end else if (bp_r >= out_size_r) begin
            // stream done: byte dropped
          end else begin
            unique case (phase_r)
              PH_CODE: begin
                flag_bits_nxt  = in_byte;
                flags_left_nxt = FLAGS_PER_CODE;
                phase_nxt      = PH_ITEM;
              end
              PH_ITEM: begin
                if (flag_bits_r[7]) begin
                  win_wr.en      = 1'b1;
                  win_wr.addr    = bp_r[AW-1:0];
                  win_wr.data    = in_byte;
                  bp_nxt         = bp_inc;
                  out_valid_nxt  = 1'b1;
                  out_data_nxt   = DATA_W'(in_byte);
                  out_count_nxt  = CNT_W'(1);
                  out_last_nxt   = 1'b1;
                  out_done_nxt   = bp_inc >= out_size_r;
                  out_status_nxt = STATUS_OK;
                  flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
                  flags_left_nxt = fin_left;
                  phase_nxt      = (fin_left != 4'd0) ? PH_ITEM : PH_CODE;
                end else begin
                  ref1_nxt  = in_byte;
                  phase_nxt = PH_SECOND;
                end
              end
              PH_SECOND, PH_THIRD: begin
                if (phase_r == PH_SECOND) begin
                  ref2_nxt = in_byte;
                end
                if (phase_r == PH_SECOND && ref1_r[7:4] == 4'd0) begin
                  phase_nxt = PH_THIRD;
                end else begin
                  state_nxt      = S_RUN;
                  rd_left_nxt    = len_c;
                  run_left_nxt   = len_c;
                  st_v_nxt       = 1'b0;
                  beat_cnt_nxt   = '0;
                  beat_data_nxt  = '0;
                  rp_nxt         = bp_r[AW-1:0] - AW'(ref_dist);
                  zeros_nxt      = pre_start ? ref_dist - bp_r[DIST_W-1:0] : '0;
                  run_status_nxt = pre_start ? STATUS_BEFORE_START
                                             : (clip ? STATUS_CLIPPED : STATUS_OK);
                end
              end
              default: phase_nxt = PH_CODE;
            endcase
          end
        end
      end

      S_RUN: begin
        // freeze the whole copy pipe when a beat cannot be placed
        if (!push || out_free) begin
          if (st_v_r) begin
            win_wr.en    = 1'b1;
            win_wr.addr  = bp_r[AW-1:0];
            win_wr.data  = win_q;
            bp_nxt       = bp_inc;
            run_left_nxt = run_left_r - LEN_W'(1);
            if (push) begin
              out_valid_nxt  = 1'b1;
              out_data_nxt   = beat_ins;
              out_count_nxt  = {1'b0, beat_cnt_r} + CNT_W'(1);
              out_last_nxt   = (run_left_r == LEN_W'(1));
              out_done_nxt   = bp_inc >= out_size_r;
              out_status_nxt = run_status_r;
              beat_cnt_nxt   = '0;
              beat_data_nxt  = '0;
            end else begin
              beat_cnt_nxt  = beat_cnt_r + 3'd1;
              beat_data_nxt = beat_ins;
            end
            if (run_left_r == LEN_W'(1)) begin
              state_nxt      = S_IDLE;
              flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
              flags_left_nxt = fin_left;
              phase_nxt      = (fin_left != 4'd0) ? PH_ITEM : PH_CODE;
            end
          end
          if (rd_left_r != '0) begin
            win_rd.en   = 1'b1;
            win_rd.addr = rp_r;
            win_rd.zero = (zeros_r != '0);
            rp_nxt      = rp_r + AW'(1);
            rd_left_nxt = rd_left_r - LEN_W'(1);
            zeros_nxt   = (zeros_r != '0) ? zeros_r - DIST_W'(1) : zeros_r;
            st_v_nxt    = 1'b1;
          end else begin
            st_v_nxt = 1'b0;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rp_r         <= rp_nxt;
    zeros_r      <= zeros_nxt;
    run_status_r <= run_status_nxt;
    beat_data_r  <= beat_data_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_CODE;
      hdr_cnt_r    <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      bp_r         <= '0;
      out_size_r   <= '0;
      rd_left_r    <= '0;
      run_left_r   <= '0;
      st_v_r       <= 1'b0;
      beat_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      ref1_r       <= '0;
      ref2_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      bp_r         <= bp_nxt;
      out_size_r   <= out_size_nxt;
      rd_left_r    <= rd_left_nxt;
      run_left_r   <= run_left_nxt;
      st_v_r       <= st_v_nxt;
      beat_cnt_r   <= beat_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      ref1_r       <= ref1_nxt;
      ref2_r       <= ref2_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_count       = out_count_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;
  assign out_status      = out_status_r;

endmodule

>>> sv/lzbr_checker.sv
// ----------------------------------------------------------------------------
// lzbr_checker
// Port-level checks for the LZ back-reference decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "lz_backref_stream_decoder_assert.svh"

module lzbr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lzbr_pkg::DATA_W-1:0] out_data,
  input logic [lzbr_pkg::CNT_W-1:0]  out_count,
  input logic                        out_run_last,
  input logic                        out_stream_done,
  input logic [1:0]                  out_status
);
  import lzbr_pkg::*;

  // stalled beat holds
  `LZBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data) && $stable(out_count), "stalled beat changed")

  // only the closing beat of a run may be short
  `LZBR_ASSERT_NOW(a_full_beat, out_valid && !out_run_last, out_count == CNT_W'(BEAT_BYTES), "short beat before run end")

  // a clipped run ends exactly at output_size
  `LZBR_ASSERT_NOW(a_clip_done, out_valid && out_run_last && out_status == STATUS_CLIPPED, out_stream_done, "clipped run did not finish stream")

  // a blocked output keeps the input closed
  `LZBR_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall, "input open while beat blocked")

endmodule

bind lz_backref_stream_decoder lzbr_checker u_lzbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_data        (out_data),
  .out_count       (out_count),
  .out_run_last    (out_run_last),
  .out_stream_done (out_stream_done),
  .out_status      (out_status)
);
